### hdl/kwm_pkg.sv
package kwm_pkg;

    // field widths fixed by the stream format
    localparam int VAL_W = 16;
    localparam int ID_W  = 3;
    localparam int CFG_W = 4;

    // index width in the compare chain, covers the largest row of 64 cells
    localparam int IDX_W = 6;

    // result status codes
    localparam logic [1:0] STAT_ELEM       = 2'd0;
    localparam logic [1:0] STAT_REJECT     = 2'd1;
    localparam logic [1:0] STAT_EMPTY_DONE = 2'd2;

    // per-cell command from the controller
    typedef struct packed {
        logic clear;
        logic push;
        logic mark_end;
        logic pop;
    } kwm_cmd_t;

    // per-cell status back to the controller
    typedef struct packed {
        logic full;
        logic ended;
    } kwm_stat_t;

    // running minimum handed from cell to cell
    typedef struct packed {
        logic                    any;
        logic                    ready;
        logic signed [VAL_W-1:0] best_val;
        logic [IDX_W-1:0]        best_idx;
    } kwm_link_t;

endpackage

### hdl/kwm_cell.sv
module kwm_cell #(
    parameter int FIFO_DEPTH = 8,
    parameter int INDEX      = 0
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             active,
    input  kwm_pkg::kwm_cmd_t                cmd,
    input  logic signed [kwm_pkg::VAL_W-1:0] push_value,
    input  kwm_pkg::kwm_link_t               link_in,
    output kwm_pkg::kwm_link_t               link_out,
    output kwm_pkg::kwm_stat_t               stat
);

    localparam int PW = $clog2(FIFO_DEPTH);
    localparam int FW = $clog2(FIFO_DEPTH + 1);

    logic [PW-1:0] rd_ptr_reg;
    logic [PW-1:0] wr_ptr_reg;
    logic [FW-1:0] fill_reg;
    logic          ended_reg;
    logic signed [kwm_pkg::VAL_W-1:0] head_reg;
    logic signed [kwm_pkg::VAL_W-1:0] store_mem [FIFO_DEPTH];

    logic [PW-1:0] rd_inc;
    logic [PW-1:0] wr_inc;
    logic [PW-1:0] rd_addr;

    kwm_pkg::kwm_link_t link_next;
    kwm_pkg::kwm_link_t link_reg;

    // pointer wrap
    assign rd_inc  = (rd_ptr_reg == PW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
    assign wr_inc  = (wr_ptr_reg == PW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_addr = cmd.pop ? rd_inc : rd_ptr_reg;

    // fifo control state
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clear) begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            fill_reg   <= '0;
            ended_reg  <= 1'b0;
        end else begin
            if (cmd.push) begin
                wr_ptr_reg <= wr_inc;
                fill_reg   <= fill_reg + 1'b1;
            end
            if (cmd.pop) begin
                rd_ptr_reg <= rd_inc;
                fill_reg   <= fill_reg - 1'b1;
            end
            if (cmd.mark_end) begin
                ended_reg <= 1'b1;
            end
        end
    end

    // element store, head held in a registered read
    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            store_mem[wr_ptr_reg] <= push_value;
        end
        if (cmd.push && fill_reg == '0) begin
            head_reg <= push_value;
        end else begin
            head_reg <= store_mem[rd_addr];
        end
    end

    // fold own head into the running minimum, lower index wins ties; an empty cell not yet ended clears ready
    always_comb begin
        link_next = link_in;
        if (active) begin
            if (fill_reg == '0) begin
                if (!ended_reg) begin
                    link_next.ready = 1'b0;
                end
            end else if (!link_in.any || head_reg < link_in.best_val) begin
                link_next.any      = 1'b1;
                link_next.best_val = head_reg;
                link_next.best_idx = kwm_pkg::IDX_W'(INDEX);
            end
        end
    end

    // chain stage register
    always_ff @(posedge aclk) begin
        link_reg <= link_next;
    end

    assign link_out   = link_reg;
    assign stat.full  = (fill_reg == FW'(FIFO_DEPTH));
    assign stat.ended = ended_reg;

endmodule

### hdl/k_way_sorted_stream_merge.sv
// channel   | direction | tdata (low bit up)                 | tuser / tlast
// s_*       | in        | list_id[2:0] value[18:3] pad       | tuser = is_end
// m_*       | out       | merged_value[15:0] source_list     | tuser = status, merge_done
//           |           | [18:16] pad                        | tlast = last_of_run
// cfg_*     | in        | cfg_wr_data = lists_in_use         | written when cfg_wr_en
//
// an item is accepted in ST_IDLE, then runs one selection pass (ST_SWEEP, then ST_DECIDE)
// per emitted element and one final pass that finds nothing more to emit; the sweep
// length is set by the registered compare chain running through the cells
// a completed merge that holds a reject sends it, then a trailing empty-done beat from ST_FIN
// reset and a configuration write both empty every list fifo and end flag
// the result register lets the next item in while a beat waits on m_tready

module k_way_sorted_stream_merge #(
    parameter int LISTS      = 8,
    parameter int FIFO_DEPTH = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,    // list_id[2:0], value[18:3], zero pad
    input  logic        s_tuser,    // is_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // merged_value[15:0], source_list[18:16], zero pad
    output logic        m_tlast,
    output logic [2:0]  m_tuser,    // status[1:0], merge_done[2]
    input  logic        cfg_wr_en,
    input  logic [3:0]  cfg_wr_data
);

    localparam int NW = $clog2(LISTS + 1);
    localparam int IW = $clog2(LISTS);
    localparam int VW = kwm_pkg::VAL_W;
    localparam int DW = kwm_pkg::ID_W;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SWEEP  = 2'd1;
    localparam logic [1:0] ST_DECIDE = 2'd2;
    localparam logic [1:0] ST_FIN    = 2'd3;

    // input beat fields
    logic [DW-1:0]        s_id;
    logic signed [VW-1:0] s_value;
    assign s_id    = s_tdata[2:0];
    assign s_value = s_tdata[18:3];

    // configuration register and clamp
    logic [kwm_pkg::CFG_W-1:0] cfg_reg;
    logic [NW-1:0]             n_act;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= kwm_pkg::CFG_W'(8);
        end else if (cfg_wr_en) begin
            cfg_reg <= cfg_wr_data;
        end
    end

    always_comb begin
        if (cfg_reg == '0) begin
            n_act = NW'(1);
        end else if (32'(cfg_reg) > LISTS) begin
            n_act = NW'(LISTS);
        end else begin
            n_act = NW'(cfg_reg);
        end
    end

    // controller registers
    logic [1:0]           state_reg, state_next;
    logic [IW-1:0]        cnt_reg, cnt_next;
    logic                 pend_valid_reg, pend_valid_next;
    logic                 pend_elem_reg, pend_elem_next;
    logic signed [VW-1:0] pend_val_reg, pend_val_next;
    logic [DW-1:0]        pend_src_reg, pend_src_next;
    logic [DW-1:0]        id_reg, id_next;
    logic                 m_valid_reg, m_valid_next;
    logic signed [VW-1:0] m_val_reg, m_val_next;
    logic [DW-1:0]        m_src_reg, m_src_next;
    logic [1:0]           m_status_reg, m_status_next;
    logic                 m_done_reg, m_done_next;
    logic                 m_last_reg, m_last_next;

    // cell row
    kwm_pkg::kwm_stat_t cell_stat [LISTS];
    kwm_pkg::kwm_cmd_t  cell_cmd  [LISTS];
    kwm_pkg::kwm_link_t link      [LISTS + 1];
    kwm_pkg::kwm_link_t chain_out;
    logic [LISTS-1:0]   act_vec;

    logic          in_acc;
    logic [IW-1:0] sidx;
    logic          in_range;
    logic          sel_full;
    logic          sel_ended;
    logic          do_push;
    logic          do_end;
    logic          rejected;
    logic          do_pop;
    logic          rearm;
    logic          out_free;
    logic          emit;
    logic          complete;

    logic                 ld;
    logic signed [VW-1:0] ld_val;
    logic [DW-1:0]        ld_src;
    logic [1:0]           ld_status;
    logic                 ld_done;
    logic                 ld_last;

    assign link[0]   = '{any: 1'b0, ready: 1'b1, best_val: '0, best_idx: '0};
    assign chain_out = link[LISTS];

    genvar gi;
    generate
        for (gi = 0; gi < LISTS; gi++) begin : g_cell
            assign act_vec[gi]           = (NW'(gi) < n_act);
            assign cell_cmd[gi].clear    = cfg_wr_en || rearm;
            assign cell_cmd[gi].push     = do_push && (sidx == IW'(gi));
            assign cell_cmd[gi].mark_end = do_end && (sidx == IW'(gi));
            assign cell_cmd[gi].pop      = do_pop &&
                                           (chain_out.best_idx == kwm_pkg::IDX_W'(gi));

            kwm_cell #(
                .FIFO_DEPTH (FIFO_DEPTH),
                .INDEX      (gi)
            ) u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .active     (act_vec[gi]),
                .cmd        (cell_cmd[gi]),
                .push_value (s_value),
                .link_in    (link[gi]),
                .link_out   (link[gi + 1]),
                .stat       (cell_stat[gi])
            );
        end
    endgenerate

    // input beat decode
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_acc    = s_tvalid && s_tready;
    assign sidx      = IW'(s_id);
    assign in_range  = (32'(s_id) < 32'(n_act));
    assign sel_full  = cell_stat[sidx].full;
    assign sel_ended = cell_stat[sidx].ended;
    assign do_end    = in_acc && in_range && s_tuser && !sel_ended;
    assign do_push   = in_acc && in_range && !s_tuser && !sel_ended && !sel_full;
    assign rejected  = !in_range || sel_ended || (!s_tuser && sel_full);

    assign out_free = !m_valid_reg || m_tready;
    assign emit     = chain_out.any && chain_out.ready;
    assign complete = chain_out.ready && !chain_out.any;

    // sequencer: sweep the chain, hold one result back to place the done flag
    always_comb begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        pend_valid_next = pend_valid_reg;
        pend_elem_next  = pend_elem_reg;
        pend_val_next   = pend_val_reg;
        pend_src_next   = pend_src_reg;
        id_next         = id_reg;
        do_pop          = 1'b0;
        rearm           = 1'b0;
        ld              = 1'b0;
        ld_val          = pend_val_reg;
        ld_src          = pend_src_reg;
        ld_status       = pend_elem_reg ? kwm_pkg::STAT_ELEM : kwm_pkg::STAT_REJECT;
        ld_done         = 1'b0;
        ld_last         = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    pend_valid_next = rejected;
                    pend_elem_next  = 1'b0;
                    pend_val_next   = s_value;
                    pend_src_next   = s_id;
                    id_next         = s_id;
                    cnt_next        = '0;
                    state_next      = ST_SWEEP;
                end
            end
            ST_SWEEP: begin
                if (cnt_reg == IW'(LISTS - 1)) begin
                    state_next = ST_DECIDE;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_DECIDE: begin
                if (out_free) begin
                    if (emit) begin
                        ld              = pend_valid_reg;
                        pend_valid_next = 1'b1;
                        pend_elem_next  = 1'b1;
                        pend_val_next   = chain_out.best_val;
                        pend_src_next   = chain_out.best_idx[DW-1:0];
                        do_pop          = 1'b1;
                        cnt_next        = '0;
                        state_next      = ST_SWEEP;
                    end else if (complete) begin
                        rearm           = 1'b1;
                        pend_valid_next = 1'b0;
                        ld              = 1'b1;
                        if (pend_valid_reg && pend_elem_reg) begin
                            ld_done    = 1'b1;
                            ld_last    = 1'b1;
                            state_next = ST_IDLE;
                        end else if (pend_valid_reg) begin
                            state_next = ST_FIN;
                        end else begin
                            ld_val     = '0;
                            ld_src     = id_reg;
                            ld_status  = kwm_pkg::STAT_EMPTY_DONE;
                            ld_done    = 1'b1;
                            ld_last    = 1'b1;
                            state_next = ST_IDLE;
                        end
                    end else begin
                        ld              = pend_valid_reg;
                        ld_last         = 1'b1;
                        pend_valid_next = 1'b0;
                        state_next      = ST_IDLE;
                    end
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    ld         = 1'b1;
                    ld_val     = '0;
                    ld_src     = id_reg;
                    ld_status  = kwm_pkg::STAT_EMPTY_DONE;
                    ld_done    = 1'b1;
                    ld_last    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // result register
    always_comb begin
        m_valid_next  = m_valid_reg;
        m_val_next    = m_val_reg;
        m_src_next    = m_src_reg;
        m_status_next = m_status_reg;
        m_done_next   = m_done_reg;
        m_last_next   = m_last_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        if (ld) begin
            m_valid_next  = 1'b1;
            m_val_next    = ld_val;
            m_src_next    = ld_src;
            m_status_next = ld_status;
            m_done_next   = ld_done;
            m_last_next   = ld_last;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        pend_elem_reg <= pend_elem_next;
        pend_val_reg  <= pend_val_next;
        pend_src_reg  <= pend_src_next;
        id_reg        <= id_next;
        m_val_reg     <= m_val_next;
        m_src_reg     <= m_src_next;
        m_status_reg  <= m_status_next;
        m_done_reg    <= m_done_next;
        m_last_reg    <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'b0, m_src_reg, m_val_reg};
    assign m_tlast  = m_last_reg;
    assign m_tuser  = {m_done_reg, m_status_reg};

endmodule

### hdl/kwm_port_checker.sv
module kwm_port_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tlast,
    input logic [2:0]  m_tuser
);

    // a stalled result beat holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=>
            m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
        else $error("result beat changed while stalled");

    // the done flag always closes the run of its input
    a_done_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[2] |-> m_tlast)
        else $error("merge_done without last_of_run");

    // empty-done beat carries done, last and a zero value
    a_empty_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1:0] == kwm_pkg::STAT_EMPTY_DONE |->
            m_tuser[2] && m_tlast && m_tdata[15:0] == 16'd0)
        else $error("malformed empty-done beat");

    // a reject never finishes a merge
    a_reject_no_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1:0] == kwm_pkg::STAT_REJECT |-> !m_tuser[2])
        else $error("reject beat flagged done");

    // status is always one of the three defined codes
    a_status_known: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1:0] != kwm_pkg::STAT_ELEM &&
            m_tuser[1:0] != kwm_pkg::STAT_REJECT |-> m_tuser[1:0] == kwm_pkg::STAT_EMPTY_DONE)
        else $error("unknown status code");

endmodule

bind k_way_sorted_stream_merge kwm_port_checker u_kwm_port_checker (.*);
